// ===== src/size_class_free_list_allocator_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCFLA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCFLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ===== src/scfla_pkg.sv =====
package scfla_pkg;

  localparam int AddrW       = 12;
  localparam int ArenaGran   = 4096;
  localparam int NumClasses  = 16;
  localparam int ClsW        = 4;
  localparam int RefillBlks  = 20;
  localparam int MaxSmall    = 128;
  localparam int AlignShift  = 3;
  localparam logic [12:0] GrantedMax = 13'd8191;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FREED = 2'd1;
  localparam logic [1:0] STAT_LARGE = 2'd2;
  localparam logic [1:0] STAT_OOM   = 2'd3;

  // Class of a block of g granules: g-1, clamped to the largest class.
  function automatic logic [ClsW-1:0] class_of(input logic [12:0] g);
    logic [12:0] c;
    c = (g == 13'd0) ? 13'd0 : g - 13'd1;
    class_of = (c >= 13'(NumClasses)) ? ClsW'(NumClasses - 1) : c[ClsW-1:0];
  endfunction

  // Granules for a small byte count (at most MaxSmall), rounded up.
  function automatic logic [12:0] granules_of(input logic [15:0] bytes);
    logic [15:0] s;
    s = bytes + 16'((1 << AlignShift) - 1);
    granules_of = 13'(s >> AlignShift);
  endfunction

endpackage

// ===== src/size_class_free_list_allocator_unit.sv =====
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+---------------------------------------
// request   | in        | start, busy                  | command, request_bytes, old_bytes,
//           |           |                              | block_address
// result    | out       | result_valid_o (strobe)      | granted_address, status
// config    | in        | cfg_valid_i, cfg_ready_o     | cfg_data_i (heap limit, granules)
//
// Busy stays high during a free, a list pop, a refill that links up to nineteen fresh blocks
// and a scavenge scan of up to sixteen lists, as the link memory, with one write port and one
// read port, writes or reads one link per cycle.
// Reset empties every list and the pool; the link memory itself is not cleared.
// The result is shown for one cycle only and the receiver cannot stall it; busy stays
// high from acceptance until the cycle the result strobe is raised.
module size_class_free_list_allocator_unit
  import scfla_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       command_i,
  input  logic [15:0]      request_bytes_i,
  input  logic [15:0]      old_bytes_i,
  input  logic [AddrW-1:0] block_address_i,
  output logic             result_valid_o,
  output logic [AddrW-1:0] granted_address_o,
  output logic [1:0]       status_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [AddrW-1:0] cfg_data_i
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FREE  = 4'd1;
  localparam logic [3:0] S_ALLOC = 4'd2;
  localparam logic [3:0] S_POPW  = 4'd3;
  localparam logic [3:0] S_LEFT  = 4'd4;
  localparam logic [3:0] S_GROW  = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_SCAVW = 4'd7;
  localparam logic [3:0] S_CARVE = 4'd8;
  localparam logic [3:0] S_LINK  = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [1:0]       cmd_q;
  logic [15:0]      req_q, old_q;
  logic [AddrW-1:0] addr_q;
  logic [12:0]      g_q, g_d;
  logic [ClsW-1:0]  cls_q, cls_d;
  logic [ClsW-1:0]  scan_q, scan_d;
  logic [13:0]      a_q, a_d;
  logic [4:0]       k_q, k_d;
  logic [12:0]      base_q, base_d;
  logic [AddrW-1:0] heads_q [NumClasses];
  logic [12:0]      pool_start_q, pool_start_d;
  logic [12:0]      pool_end_q, pool_end_d;
  logic [12:0]      heap_top_q, heap_top_d;
  logic [12:0]      heap_granted_q, heap_granted_d;
  logic [AddrW-1:0] limit_q;
  logic             res_valid_q, res_valid_d;
  logic [AddrW-1:0] res_addr_q, res_addr_d;
  logic [1:0]       res_status_q, res_status_d;

  // One read and one write place on the class heads per cycle.
  logic [ClsW-1:0]  hidx;
  logic [AddrW-1:0] head_rd;
  logic             head_we;
  logic [AddrW-1:0] head_wd;

  // Link memory ports.
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  logic [12:0] left;
  logic [15:0] free_bytes;
  logic [12:0] extra;
  logic [10:0] get;
  logic [13:0] new_top;
  logic        grow_ok;
  logic [13:0] two_g;
  logic        accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign left       = (pool_end_q > pool_start_q) ? pool_end_q - pool_start_q : 13'd0;
  assign free_bytes = (cmd_q == CMD_FREE) ? req_q : old_q;
  assign two_g      = {g_q, 1'b0};

  // Pool growth: twice the refill need plus one sixteenth of the heap, in granules.
  assign extra   = 13'(((({heap_granted_q, 3'b000} >> 4) + 16'd7) >> AlignShift));
  assign get     = 11'(({g_q, 1'b0} * 13'(RefillBlks)) + extra);
  assign new_top = {1'b0, heap_top_q} + 14'(get);
  assign grow_ok = (new_top <= 14'({2'b00, limit_q} + 14'd1)) && (new_top <= 14'(ArenaGran));

  always_comb begin
    case (state_q)
      S_FREE:          hidx = class_of(granules_of(free_bytes));
      S_LEFT:          hidx = class_of(left);
      S_SCAN, S_SCAVW: hidx = scan_q;
      default:         hidx = cls_q;
    endcase
  end
  assign head_rd = heads_q[hidx];

  always_comb begin
    state_d        = state_q;
    g_d            = g_q;
    cls_d          = cls_q;
    scan_d         = scan_q;
    a_d            = a_q;
    k_d            = k_q;
    base_d         = base_q;
    pool_start_d   = pool_start_q;
    pool_end_d     = pool_end_q;
    heap_top_d     = heap_top_q;
    heap_granted_d = heap_granted_q;
    res_valid_d    = 1'b0;
    res_addr_d     = res_addr_q;
    res_status_d   = res_status_q;
    head_we        = 1'b0;
    head_wd        = head_rd;
    ram_we         = 1'b0;
    ram_waddr      = addr_q;
    ram_wdata      = head_rd;
    ram_re         = 1'b0;
    ram_raddr      = head_rd;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_FREE;
        end
      end

      S_FREE: begin
        // Push the freed block onto its class list, unless it is large or null.
        if (cmd_q != CMD_ALLOC && free_bytes <= 16'(MaxSmall) && addr_q != '0) begin
          if (!(cmd_q == CMD_FREE && req_q > 16'(MaxSmall))) begin
            ram_we    = 1'b1;
            ram_waddr = addr_q;
            ram_wdata = head_rd;
            head_we   = 1'b1;
            head_wd   = addr_q;
          end
        end
        if (cmd_q == CMD_FREE) begin
          res_valid_d  = 1'b1;
          res_addr_d   = '0;
          res_status_d = (req_q > 16'(MaxSmall)) ? STAT_LARGE : STAT_FREED;
          state_d      = S_IDLE;
        end else begin
          state_d = S_ALLOC;
        end
        // Alloc class is settled here; a zero-byte request counts as one granule.
        cls_d = class_of((granules_of(req_q) == 13'd0) ? 13'd1 : granules_of(req_q));
        g_d   = 13'(class_of((granules_of(req_q) == 13'd0) ? 13'd1 : granules_of(req_q)))
                + 13'd1;
      end

      S_ALLOC: begin
        if (req_q > 16'(MaxSmall)) begin
          res_valid_d  = 1'b1;
          res_addr_d   = '0;
          res_status_d = STAT_LARGE;
          state_d      = S_IDLE;
        end else if (head_rd != '0) begin
          ram_re     = 1'b1;
          ram_raddr  = head_rd;
          res_addr_d = head_rd;
          state_d    = S_POPW;
        end else if (left >= g_q) begin
          state_d = S_CARVE;
        end else begin
          state_d = S_LEFT;
        end
      end

      S_POPW: begin
        head_we      = 1'b1;
        head_wd      = ram_rdata;
        res_valid_d  = 1'b1;
        res_status_d = STAT_OK;
        state_d      = S_IDLE;
      end

      S_LEFT: begin
        // Leftover of the pool goes to its own class before the pool is refilled.
        if (left != 13'd0) begin
          ram_we    = 1'b1;
          ram_waddr = pool_start_q[AddrW-1:0];
          ram_wdata = head_rd;
          head_we   = 1'b1;
          head_wd   = pool_start_q[AddrW-1:0];
        end
        pool_start_d = '0;
        pool_end_d   = '0;
        state_d      = S_GROW;
      end

      S_GROW: begin
        if (grow_ok) begin
          pool_start_d   = heap_top_q;
          pool_end_d     = new_top[12:0];
          heap_top_d     = new_top[12:0];
          heap_granted_d = (14'(heap_granted_q) + 14'(get) > 14'(GrantedMax)) ? GrantedMax
                           : heap_granted_q + 13'(get);
          state_d        = S_CARVE;
        end else begin
          scan_d  = cls_q;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // Scavenge one block of this class or a larger one as the new pool.
        if (head_rd != '0) begin
          ram_re    = 1'b1;
          ram_raddr = head_rd;
          base_d    = 13'(head_rd);
          state_d   = S_SCAVW;
        end else if (scan_q == ClsW'(NumClasses - 1)) begin
          res_valid_d  = 1'b1;
          res_addr_d   = '0;
          res_status_d = STAT_OOM;
          state_d      = S_IDLE;
        end else begin
          scan_d = scan_q + ClsW'(1);
        end
      end

      S_SCAVW: begin
        head_we      = 1'b1;
        head_wd      = ram_rdata;
        pool_start_d = base_q;
        pool_end_d   = base_q + 13'(scan_q) + 13'd1;
        state_d      = S_CARVE;
      end

      S_CARVE: begin
        // First block is granted; the rest, if a second one fits, get linked.
        base_d       = pool_start_q;
        res_addr_d   = pool_start_q[AddrW-1:0];
        res_status_d = STAT_OK;
        if (RefillBlks > 1 && 14'(pool_start_q) + two_g <= 14'(pool_end_q)) begin
          head_we = 1'b1;
          head_wd = AddrW'(pool_start_q + g_q);
          a_d     = 14'(pool_start_q) + 14'(g_q);
          k_d     = 5'd1;
          state_d = S_LINK;
        end else begin
          pool_start_d = pool_start_q + g_q;
          res_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = a_q[AddrW-1:0];
        if ((6'(k_q) + 6'd1 < 6'(RefillBlks)) && (a_q + two_g <= 14'(pool_end_q))) begin
          ram_wdata = AddrW'(a_q + 14'(g_q));
          a_d       = a_q + 14'(g_q);
          k_d       = k_q + 5'd1;
        end else begin
          ram_wdata    = '0;
          pool_start_d = 13'(a_q + 14'(g_q));
          res_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  scfla_link_ram u_links (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      pool_start_q   <= '0;
      pool_end_q     <= '0;
      heap_top_q     <= 13'd1;
      heap_granted_q <= '0;
      limit_q        <= 12'd4095;
      res_valid_q    <= 1'b0;
      for (int i = 0; i < NumClasses; i++) begin
        heads_q[i] <= '0;
      end
    end else begin
      state_q        <= state_d;
      pool_start_q   <= pool_start_d;
      pool_end_q     <= pool_end_d;
      heap_top_q     <= heap_top_d;
      heap_granted_q <= heap_granted_d;
      res_valid_q    <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (head_we) begin
        heads_q[hidx] <= head_wd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      req_q  <= request_bytes_i;
      old_q  <= old_bytes_i;
      addr_q <= block_address_i;
    end
    g_q          <= g_d;
    cls_q        <= cls_d;
    scan_q       <= scan_d;
    a_q          <= a_d;
    k_q          <= k_d;
    base_q       <= base_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
  end

  assign result_valid_o    = res_valid_q;
  assign granted_address_o = res_addr_q;
  assign status_o          = res_status_q;

endmodule

// ===== src/scfla_link_ram.sv =====
module scfla_link_ram
  import scfla_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [AddrW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [AddrW-1:0] rdata_o
);

  logic [AddrW-1:0] mem [ArenaGran];
  logic [AddrW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/scfla_checker.sv =====
`include "size_class_free_list_allocator_unit_defines.svh"

module scfla_checker
  import scfla_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_valid_o,
  input logic [AddrW-1:0] granted_address_o,
  input logic [1:0]       status_o
);

  `SCFLA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `SCFLA_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, result_valid_o, !result_valid_o)
  `SCFLA_ASSERT_NOW(a_done_idle, clk_i, rst_ni, result_valid_o, !busy)
  `SCFLA_ASSERT_NOW(a_no_addr_on_fail, clk_i, rst_ni,
    result_valid_o && status_o != STAT_OK, granted_address_o == '0)

endmodule

bind size_class_free_list_allocator_unit scfla_checker u_scfla_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .result_valid_o    (result_valid_o),
  .granted_address_o (granted_address_o),
  .status_o          (status_o)
);
